// ----- rtl/bscp_pkg.sv -----
// bscp_pkg: shared types and constants for the billboard sprite column projector
// depends on nothing; used by the interfaces and the top level
`default_nettype none
package bscp_pkg;
  localparam int SCREEN_COLUMNS_DEF = 64;
  localparam int SCREEN_ROWS_DEF    = 64;
  localparam int DEPTH_ENTRIES      = 64;
  localparam int COL_W              = 6;
  localparam int DEPTH_W            = 16;
  localparam int DIV_W              = 48;
  localparam int CFG_IDX_W          = 3;

  localparam logic OP_DEPTH  = 1'b0;
  localparam logic OP_SPRITE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_POS_X  = 3'd0,
    CFG_CAMERA_POS_Y  = 3'd1,
    CFG_VIEW_DIR_X    = 3'd2,
    CFG_VIEW_DIR_Y    = 3'd3,
    CFG_IMAGE_PLANE_X = 3'd4,
    CFG_IMAGE_PLANE_Y = 3'd5
  } cfg_idx_t;

  localparam logic signed [15:0] RST_VIEW_DIR_X    = -16'sd16384;
  localparam logic signed [15:0] RST_IMAGE_PLANE_Y = 16'sd10813;
endpackage
`default_nettype wire

// ----- rtl/bscp_ifs.sv -----
// bscp channel interfaces: sprite input, stripe output and configuration write
// depends on bscp_pkg for field widths
`default_nettype none
interface bscp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [bscp_pkg::COL_W-1:0]       column_index;
  logic [bscp_pkg::DEPTH_W-1:0]     wall_depth;
  logic signed [15:0]               sprite_x;
  logic signed [15:0]               sprite_y;
  logic [7:0]                       texture_id;
  logic [8:0]                       texture_width;
  modport source (output valid, operation, column_index, wall_depth, sprite_x, sprite_y,
                  texture_id, texture_width, input ready);
  modport sink (input valid, operation, column_index, wall_depth, sprite_x, sprite_y,
                texture_id, texture_width, output ready);
endinterface

interface bscp_out_if;
  logic                       valid;
  logic                       ready;
  logic [bscp_pkg::COL_W-1:0] stripe_column;
  logic [7:0]                 texel_column;
  logic signed [15:0]         top_row;
  logic signed [15:0]         bottom_row;
  logic [7:0]                 texture_tag;
  logic                       last_stripe;
  modport source (output valid, stripe_column, texel_column, top_row, bottom_row,
                  texture_tag, last_stripe, input ready);
  modport sink (input valid, stripe_column, texel_column, top_row, bottom_row,
                texture_tag, last_stripe, output ready);
endinterface

interface bscp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bscp_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/billboard_sprite_column_projector.sv -----
// billboard_sprite_column_projector: sprite camera transform, projection and stripe walk
// depends on bscp_pkg, bscp_ifs (channel interfaces) and bscp_ram (depth store)
//
// usage:
//   in_ch carries one word per operation. operation 0 writes wall_depth into the
//   depth store at column_index. operation 1 projects a sprite and emits zero
//   or more stripe words on out_ch, the final one with last_stripe set.
//   cfg_ch writes the six camera registers (index 0..5); always ready. the user
//   must write them only while the block is idle; the block does not enforce it.
//   other indexes are ignored. a sprite runs the multiplies, then four 48-step
//   divisions on one shared restoring divider, then a walk over each column of
//   the clamped span; the shared multiplier and the divider serialise this work.
//   in_ch.ready is high only when no sprite is in flight and no word waits on out_ch.
//   results pass through one output register and one held stripe, so the last
//   flag is known before a word leaves; a stalled receiver stalls the walk.
//   reset (rst_n low, synchronous) restores the camera registers and marks all
//   depth entries as zero through per-entry valid bits.
`default_nettype none
module billboard_sprite_column_projector #(
  parameter int SCREEN_COLUMNS = bscp_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = bscp_pkg::SCREEN_ROWS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  bscp_in_if.sink     in_ch,
  bscp_out_if.source  out_ch,
  bscp_cfg_if.sink    cfg_ch
);
  localparam int DW = bscp_pkg::DIV_W;
  localparam int CW = bscp_pkg::COL_W;
  localparam int HALF_COLS = SCREEN_COLUMNS / 2;
  localparam int HALF_ROWS = SCREEN_ROWS / 2;
  localparam logic signed [49:0] LAST_COL = 50'(SCREEN_COLUMNS - 1);
  localparam logic signed [49:0] MID_ROW  = 50'(HALF_ROWS);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_SIGN, S_TEST, S_DIV1LD, S_SZM, S_DIV2LD, S_SPAN, S_TXM, S_DIV3LD,
    S_DIV, S_POST, W_RD, W_MUL, W_CMP, S_FLUSH
  } state_t;

  typedef enum logic [1:0] {J_SX, J_SIZE, J_TEX0, J_STEP} div_job_t;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) return 16'sd32767;
    else if (v < -50'sd32768) return -16'sd32768;
    else return v[15:0];
  endfunction

  // camera registers
  logic signed [15:0] cam_x_r, cam_y_r, dir_x_r, dir_y_r, pln_x_r, pln_y_r;

  state_t   state_r;
  div_job_t job_r;
  logic [2:0] k_r;

  // sprite item
  logic signed [16:0] dx_r, dy_r;
  logic [7:0]         tag_r;
  logic [8:0]         texw_r;

  logic signed [35:0] det_r, nx_r, ny_r;
  logic signed [53:0] prod_r;
  logic               sx_neg_r;
  logic signed [48:0] sx_r;
  logic [DW-1:0]      size_r;

  // shared divider
  logic [DW-1:0] div_num_r, div_den_r;
  logic [DW:0]   div_rem_r;
  logic [5:0]    div_cnt_r;
  logic [DW:0]   rem_sh, rem_sub;

  // span and walk
  logic [CW-1:0]      s_r, end_r;
  logic signed [49:0] off0_r;
  logic signed [15:0] top_r, bot_r;
  logic [7:0]         tq_r, qs_r;
  logic [DW-1:0]      tr_r, rs_r;

  // held stripe and output register
  logic          held_v_r;
  logic [CW-1:0] held_col_r;
  logic [7:0]    held_tex_r;
  logic          out_v_r;
  logic [CW-1:0] out_col_r;
  logic [7:0]    out_tex_r;
  logic          out_last_r;

  logic [bscp_pkg::DEPTH_ENTRIES-1:0] dvalid_r;
  logic [bscp_pkg::DEPTH_W-1:0]       ram_rdata;
  logic                               in_acc, ram_we;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul_p;

  // span arithmetic
  logic signed [49:0] half_w, lo_w, hi_w, st_w, en_w;
  logic [DW:0]        tsum;
  logic               out_free, visible, out_load;
  logic [15:0]        z_w;
  logic signed [35:0] nxny;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign ram_we   = in_acc && (in_ch.operation == bscp_pkg::OP_DEPTH);
  assign out_free = !out_v_r || out_ch.ready;
  assign z_w      = dvalid_r[s_r] ? ram_rdata : 16'd0;
  assign nxny     = ny_r + nx_r;

  // the output register takes the held stripe this cycle
  assign out_load = out_free && held_v_r &&
                    (((state_r == W_CMP) && visible) || (state_r == S_FLUSH));

  bscp_ram #(.WIDTH(bscp_pkg::DEPTH_W), .DEPTH(bscp_pkg::DEPTH_ENTRIES)) u_depth (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.column_index),
    .wdata (in_ch.wall_depth),
    .raddr (s_r),
    .rdata (ram_rdata)
  );

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL: begin
        unique case (k_r)
          3'd0: begin mul_a = 36'(pln_x_r); mul_b = 18'(dir_y_r); end
          3'd1: begin mul_a = 36'(dir_x_r); mul_b = 18'(pln_y_r); end
          3'd2: begin mul_a = 36'(dx_r);    mul_b = 18'(dir_y_r); end
          3'd3: begin mul_a = 36'(dy_r);    mul_b = 18'(dir_x_r); end
          3'd4: begin mul_a = 36'(dy_r);    mul_b = 18'(pln_x_r); end
          3'd5: begin mul_a = 36'(dx_r);    mul_b = 18'(pln_y_r); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_TEST:  begin mul_a = nxny;          mul_b = 18'(HALF_COLS); end
      S_SZM:   begin mul_a = det_r;         mul_b = 18'(SCREEN_ROWS); end
      S_TXM:   begin mul_a = off0_r[35:0];  mul_b = $signed({9'd0, texw_r}); end
      W_MUL:   begin mul_a = det_r;         mul_b = $signed({2'b00, z_w}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // restoring divider step
  assign rem_sh  = {div_rem_r[DW-1:0], div_num_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, div_den_r};

  // span from sx and size
  always_comb begin
    half_w = $signed({3'b000, size_r[DW-1:1]});
    lo_w   = $signed({sx_r[48], sx_r}) - half_w;
    hi_w   = $signed({sx_r[48], sx_r}) + half_w;
    st_w   = (lo_w < 50'sd0) ? 50'sd0 : lo_w;
    en_w   = (hi_w > LAST_COL) ? LAST_COL : hi_w;
  end

  assign tsum    = {1'b0, tr_r} + {1'b0, rs_r};
  assign visible = (s_r != '0) && (($signed({ny_r, 14'd0}) + 54'sd0) < prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cam_x_r    <= '0;
      cam_y_r    <= '0;
      dir_x_r    <= bscp_pkg::RST_VIEW_DIR_X;
      dir_y_r    <= '0;
      pln_x_r    <= '0;
      pln_y_r    <= bscp_pkg::RST_IMAGE_PLANE_Y;
      dvalid_r   <= '0;
      held_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      k_r        <= '0;
      div_cnt_r  <= '0;
      job_r      <= J_SX;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          bscp_pkg::CFG_CAMERA_POS_X:  cam_x_r <= cfg_ch.data;
          bscp_pkg::CFG_CAMERA_POS_Y:  cam_y_r <= cfg_ch.data;
          bscp_pkg::CFG_VIEW_DIR_X:    dir_x_r <= cfg_ch.data;
          bscp_pkg::CFG_VIEW_DIR_Y:    dir_y_r <= cfg_ch.data;
          bscp_pkg::CFG_IMAGE_PLANE_X: pln_x_r <= cfg_ch.data;
          bscp_pkg::CFG_IMAGE_PLANE_Y: pln_y_r <= cfg_ch.data;
          default: ;
        endcase
      end

      // output register drains independently of the sequencer
      if (out_v_r && out_ch.ready && !out_load) begin
        out_v_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.operation == bscp_pkg::OP_DEPTH) begin
              dvalid_r[in_ch.column_index] <= 1'b1;
            end else begin
              dx_r    <= 17'(in_ch.sprite_x) - 17'(cam_x_r);
              dy_r    <= 17'(in_ch.sprite_y) - 17'(cam_y_r);
              tag_r   <= in_ch.texture_id;
              texw_r  <= in_ch.texture_width;
              det_r   <= '0;
              nx_r    <= '0;
              ny_r    <= '0;
              k_r     <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // product of step k registers now, step k-1 accumulates
          prod_r <= mul_p;
          if (k_r != 3'd0) begin
            unique case (k_r)
              3'd1: det_r <= det_r + prod_r[35:0];
              3'd2: det_r <= det_r - prod_r[35:0];
              3'd3: nx_r  <= nx_r  + prod_r[35:0];
              3'd4: nx_r  <= nx_r  - prod_r[35:0];
              3'd5: ny_r  <= ny_r  + prod_r[35:0];
              3'd6: ny_r  <= ny_r  - prod_r[35:0];
              default: ;
            endcase
          end
          k_r <= k_r + 3'd1;
          if (k_r == 3'd6) begin
            state_r <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (det_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            if (det_r < 36'sd0) begin
              det_r <= -det_r;
              nx_r  <= -nx_r;
              ny_r  <= -ny_r;
            end
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          if (ny_r <= 36'sd0) begin
            state_r <= S_IDLE;
          end else begin
            prod_r  <= mul_p;
            state_r <= S_DIV1LD;
          end
        end
        S_DIV1LD: begin
          sx_neg_r  <= prod_r[53];
          div_num_r <= prod_r[53] ? DW'(-prod_r) : DW'(prod_r);
          div_den_r <= DW'(ny_r);
          div_rem_r <= '0;
          div_cnt_r <= '0;
          job_r     <= J_SX;
          state_r   <= S_DIV;
        end
        S_SZM: begin
          prod_r  <= mul_p;
          state_r <= S_DIV2LD;
        end
        S_DIV2LD: begin
          div_num_r <= DW'(prod_r);
          div_den_r <= DW'({ny_r, 6'd0});
          div_rem_r <= '0;
          div_cnt_r <= '0;
          job_r     <= J_SIZE;
          state_r   <= S_DIV;
        end
        S_SPAN: begin
          top_r  <= sat16(MID_ROW - half_w);
          bot_r  <= sat16(MID_ROW + half_w);
          s_r    <= CW'(st_w);
          end_r  <= CW'(en_w);
          off0_r <= st_w - lo_w;
          if (st_w >= en_w) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_TXM;
          end
        end
        S_TXM: begin
          prod_r  <= mul_p;
          state_r <= S_DIV3LD;
        end
        S_DIV3LD: begin
          div_num_r <= DW'(prod_r);
          div_den_r <= size_r;
          div_rem_r <= '0;
          div_cnt_r <= '0;
          job_r     <= J_TEX0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, div_den_r}) begin
            div_rem_r <= rem_sub;
            div_num_r <= {div_num_r[DW-2:0], 1'b1};
          end else begin
            div_rem_r <= rem_sh;
            div_num_r <= {div_num_r[DW-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'(DW - 1)) begin
            state_r <= S_POST;
          end
        end
        S_POST: begin
          unique case (job_r)
            J_SX: begin
              sx_r    <= sx_neg_r ? -$signed({1'b0, div_num_r}) : $signed({1'b0, div_num_r});
              state_r <= S_SZM;
            end
            J_SIZE: begin
              size_r  <= div_num_r;
              state_r <= S_SPAN;
            end
            J_TEX0: begin
              tq_r      <= div_num_r[7:0];
              tr_r      <= div_rem_r[DW-1:0];
              div_num_r <= DW'(texw_r);
              div_den_r <= size_r;
              div_rem_r <= '0;
              div_cnt_r <= '0;
              job_r     <= J_STEP;
              state_r   <= S_DIV;
            end
            J_STEP: begin
              qs_r     <= div_num_r[7:0];
              rs_r     <= div_rem_r[DW-1:0];
              held_v_r <= 1'b0;
              state_r  <= W_RD;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        W_RD: begin
          state_r <= W_MUL;
        end
        W_MUL: begin
          prod_r  <= mul_p;
          state_r <= W_CMP;
        end
        W_CMP: begin
          if (!(visible && held_v_r && !out_free)) begin
            if (visible) begin
              if (held_v_r) begin
                out_v_r    <= 1'b1;
                out_col_r  <= held_col_r;
                out_tex_r  <= held_tex_r;
                out_last_r <= 1'b0;
              end
              held_v_r   <= 1'b1;
              held_col_r <= s_r;
              held_tex_r <= tq_r;
            end
            // texel column of the next stripe, one step of the running quotient
            if (tsum >= {1'b0, size_r}) begin
              tr_r <= DW'(tsum - {1'b0, size_r});
              tq_r <= tq_r + qs_r + 8'd1;
            end else begin
              tr_r <= DW'(tsum);
              tq_r <= tq_r + qs_r;
            end
            s_r <= s_r + CW'(1);
            if (s_r + CW'(1) == end_r) begin
              state_r <= S_FLUSH;
            end else begin
              state_r <= W_RD;
            end
          end
        end
        S_FLUSH: begin
          if (!held_v_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_v_r    <= 1'b1;
            out_col_r  <= held_col_r;
            out_tex_r  <= held_tex_r;
            out_last_r <= 1'b1;
            held_v_r   <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a waiting word keeps tag and rows of its sprite, so no new word enters
  assign in_ch.ready          = (state_r == S_IDLE) && !out_v_r;
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_v_r;
  assign out_ch.stripe_column = out_col_r;
  assign out_ch.texel_column  = out_tex_r;
  assign out_ch.top_row       = top_r;
  assign out_ch.bottom_row    = bot_r;
  assign out_ch.texture_tag   = tag_r;
  assign out_ch.last_stripe   = out_last_r;
endmodule
`default_nettype wire

// ----- rtl/bscp_ram.sv -----
// bscp_ram: generic single write, single read ram with registered read data
// depends on nothing
`default_nettype none
module bscp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
